>>> design/iaee_pkg.sv
// shared types, character codes and helper functions of the infix expression evaluator
// no dependencies; used by the top level, the multiply/divide unit and the checker
package iaee_pkg;

    localparam int VALUE_WIDTH_DEF = 32;
    localparam int TOTAL_WIDTH     = 32;
    localparam int CHAR_WIDTH      = 8;

    localparam logic [CHAR_WIDTH-1:0] CH_PLUS   = 8'h2B;
    localparam logic [CHAR_WIDTH-1:0] CH_MINUS  = 8'h2D;
    localparam logic [CHAR_WIDTH-1:0] CH_TIMES  = 8'h2A;
    localparam logic [CHAR_WIDTH-1:0] CH_DIVIDE = 8'h2F;
    localparam logic [CHAR_WIDTH-1:0] CH_ZERO   = 8'h30;
    localparam logic [CHAR_WIDTH-1:0] CH_NINE   = 8'h39;
    localparam logic [CHAR_WIDTH-1:0] CH_SPACE  = 8'h20;

    typedef enum logic [2:0] {
        OP_PLUS   = 3'd0,
        OP_MINUS  = 3'd1,
        OP_TIMES  = 3'd2,
        OP_DIVIDE = 3'd3,
        OP_DROP   = 3'd4
    } t_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIGIT,
        S_COMMIT,
        S_ADD,
        S_MULDIV,
        S_FINISH,
        S_FINAL,
        S_EMIT
    } t_state;

    typedef enum logic [1:0] {
        MD_IDLE,
        MD_RUN,
        MD_FIX
    } t_md_state;

    typedef struct packed {
        logic start;
        logic is_div;
    } t_md_ctrl;

    function automatic logic is_digit(input logic [CHAR_WIDTH-1:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic t_op op_code(input logic [CHAR_WIDTH-1:0] c);
        t_op op;
        unique case (c)
            CH_PLUS:   op = OP_PLUS;
            CH_MINUS:  op = OP_MINUS;
            CH_TIMES:  op = OP_TIMES;
            CH_DIVIDE: op = OP_DIVIDE;
            default:   op = OP_DROP;
        endcase
        return op;
    endfunction

endpackage

>>> design/iaee_muldiv.sv
// shared multiply / signed divide unit, one operand bit per cycle
// shift-add multiply and restoring divide; depends on iaee_pkg
module iaee_muldiv #(
    parameter int VALUE_WIDTH = iaee_pkg::VALUE_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  iaee_pkg::t_md_ctrl     i_ctrl,
    input  logic [VALUE_WIDTH-1:0] i_a,
    input  logic [VALUE_WIDTH-1:0] i_b,
    output logic [VALUE_WIDTH-1:0] o_result,
    output logic                   o_done
);

    localparam int CW = $clog2(VALUE_WIDTH);
    localparam logic [CW-1:0] LAST_STEP = CW'(VALUE_WIDTH - 1);

    iaee_pkg::t_md_state r_state, n_state;
    logic [VALUE_WIDTH-1:0] r_a, n_a, r_b, n_b, r_acc, n_acc, r_res, n_res;
    logic [CW-1:0]          r_cnt, n_cnt;
    logic                   r_div, n_div, r_neg, n_neg, r_done, n_done;

    logic [VALUE_WIDTH-1:0] w_trial, w_diff, w_mac, w_a_abs, w_b_abs;
    logic                   w_ge;

    // divide: remainder stays below the divisor magnitude, so its top bit is free
    assign w_trial = {r_acc[VALUE_WIDTH-2:0], r_a[VALUE_WIDTH-1]};
    assign w_ge    = (w_trial >= r_b);
    assign w_diff  = w_trial - r_b;
    // multiply: msb of the multiplier first
    assign w_mac   = {r_acc[VALUE_WIDTH-2:0], 1'b0} + (r_b[VALUE_WIDTH-1] ? r_a : '0);
    assign w_a_abs = i_a[VALUE_WIDTH-1] ? (~i_a + VALUE_WIDTH'(1)) : i_a;
    assign w_b_abs = i_b[VALUE_WIDTH-1] ? (~i_b + VALUE_WIDTH'(1)) : i_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= iaee_pkg::MD_IDLE;
            r_cnt   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a   <= n_a;
        r_b   <= n_b;
        r_acc <= n_acc;
        r_res <= n_res;
        r_div <= n_div;
        r_neg <= n_neg;
    end

    always_comb begin
        n_state = r_state;
        n_a     = r_a;
        n_b     = r_b;
        n_acc   = r_acc;
        n_res   = r_res;
        n_cnt   = r_cnt;
        n_div   = r_div;
        n_neg   = r_neg;
        n_done  = 1'b0;
        unique case (r_state)
            iaee_pkg::MD_IDLE: begin
                if (i_ctrl.start) begin
                    n_div   = i_ctrl.is_div;
                    n_a     = i_ctrl.is_div ? w_a_abs : i_a;
                    n_b     = i_ctrl.is_div ? w_b_abs : i_b;
                    n_neg   = i_a[VALUE_WIDTH-1] ^ i_b[VALUE_WIDTH-1];
                    n_acc   = '0;
                    n_cnt   = '0;
                    n_state = iaee_pkg::MD_RUN;
                end
            end
            iaee_pkg::MD_RUN: begin
                if (r_div) begin
                    n_acc = w_ge ? w_diff : w_trial;
                    n_a   = {r_a[VALUE_WIDTH-2:0], w_ge};
                end else begin
                    n_acc = w_mac;
                    n_b   = {r_b[VALUE_WIDTH-2:0], 1'b0};
                end
                if (r_cnt == LAST_STEP) begin
                    n_cnt   = '0;
                    n_state = iaee_pkg::MD_FIX;
                end else begin
                    n_cnt = r_cnt + CW'(1);
                end
            end
            iaee_pkg::MD_FIX: begin
                if (r_div) begin
                    n_res = r_neg ? (~r_a + VALUE_WIDTH'(1)) : r_a;
                end else begin
                    n_res = r_acc;
                end
                n_done  = 1'b1;
                n_state = iaee_pkg::MD_IDLE;
            end
            default: begin
                n_state = iaee_pkg::MD_IDLE;
            end
        endcase
    end

    assign o_result = r_res;
    assign o_done   = r_done;

endmodule

>>> design/infix_arith_expression_evaluator.sv
// top level of the streaming infix expression evaluator (+ - * / at usual precedence)
// bit-serial add and times-ten datapath; uses iaee_pkg and iaee_muldiv
//
// Characters of an expression come in one item at a time; the item flagged last
// yields one result with the wrapped total and a divide-by-zero flag. The block
// holds one item at a time: o_stall is low only while it waits for a character.
// A space in the middle of an expression is absorbed without a stall; a digit
// multiplies the running number by ten through a bit-serial shift register.
// Any other character, and the last item, commits the finished number under the
// operator before it: a serial add after + or -, the shared multiply/divide unit
// (one operand bit per cycle) after * or / unless a divide has a zero divisor.
// The last item then adds a serial final sum and a load of the output register,
// which lets the next expression start while a total still waits to be taken.
module infix_arith_expression_evaluator #(
    parameter int VALUE_WIDTH = iaee_pkg::VALUE_WIDTH_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    output logic                                   o_stall,
    input  logic [iaee_pkg::CHAR_WIDTH-1:0]        i_char_code,
    input  logic                                   i_is_last,
    output logic                                   o_valid,
    input  logic                                   i_stall,
    output logic signed [iaee_pkg::TOTAL_WIDTH-1:0] o_total,
    output logic                                   o_divide_by_zero
);

    localparam int CW = $clog2(VALUE_WIDTH);
    localparam int TW = iaee_pkg::TOTAL_WIDTH;
    localparam logic [CW-1:0] LAST_STEP = CW'(VALUE_WIDTH - 1);

    iaee_pkg::t_state r_state, n_state;
    iaee_pkg::t_op    r_op, n_op;
    logic [VALUE_WIDTH-1:0] r_sum, n_sum, r_last, n_last, r_cur, n_cur;
    logic                   r_err, n_err;
    logic [CW-1:0]          r_cnt, n_cnt;
    logic [1:0]             r_carry, n_carry;
    logic [2:0]             r_hist, n_hist;
    logic [3:0]             r_dval, n_dval;
    logic [iaee_pkg::CHAR_WIDTH-1:0] r_char, n_char;
    logic                   r_is_last, n_is_last, r_commit, n_commit;
    logic                   r_o_valid, n_o_valid;
    logic signed [iaee_pkg::TOTAL_WIDTH-1:0] r_total, n_total;
    logic                   r_dbz, n_dbz;

    iaee_pkg::t_md_ctrl     w_md_ctrl;
    logic [VALUE_WIDTH-1:0] w_md_result;
    logic                   w_md_done;

    logic                   w_in_accept, w_in_digit, w_cnt_end;
    logic [2:0]             w_dig_sum;
    logic                   w_add_bit, w_add_carry, w_neg_bit, w_neg_carry;
    logic signed [TW-1:0]   w_ext;

    iaee_muldiv #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_muldiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_md_ctrl),
        .i_a     (r_last),
        .i_b     (r_cur),
        .o_result(w_md_result),
        .o_done  (w_md_done)
    );

    assign o_stall     = (r_state != iaee_pkg::S_IDLE);
    assign w_in_accept = i_valid && !o_stall;
    assign w_in_digit  = iaee_pkg::is_digit(i_char_code);
    assign w_cnt_end   = (r_cnt == LAST_STEP);

    // times ten plus digit: bit i gets cur[i-1] + cur[i-3] + digit bit + carry
    assign w_dig_sum = {2'b00, r_hist[0]} + {2'b00, r_hist[2]} + {2'b00, r_dval[0]}
                       + {1'b0, r_carry};

    // serial sum add, and serial two's complement of the number for minus
    assign w_add_bit   = r_sum[0] ^ r_last[0] ^ r_carry[0];
    assign w_add_carry = (r_sum[0] & r_last[0]) | (r_carry[0] & (r_sum[0] ^ r_last[0]));
    assign w_neg_bit   = ~r_cur[0] ^ r_carry[1];
    assign w_neg_carry = ~r_cur[0] & r_carry[1];

    assign w_ext = TW'(signed'(r_sum));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= iaee_pkg::S_IDLE;
            r_op      <= iaee_pkg::OP_PLUS;
            r_sum     <= '0;
            r_last    <= '0;
            r_cur     <= '0;
            r_err     <= 1'b0;
            r_cnt     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_op      <= n_op;
            r_sum     <= n_sum;
            r_last    <= n_last;
            r_cur     <= n_cur;
            r_err     <= n_err;
            r_cnt     <= n_cnt;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_carry   <= n_carry;
        r_hist    <= n_hist;
        r_dval    <= n_dval;
        r_char    <= n_char;
        r_is_last <= n_is_last;
        r_commit  <= n_commit;
        r_total   <= n_total;
        r_dbz     <= n_dbz;
    end

    always_comb begin
        n_state   = r_state;
        n_op      = r_op;
        n_sum     = r_sum;
        n_last    = r_last;
        n_cur     = r_cur;
        n_err     = r_err;
        n_cnt     = r_cnt;
        n_carry   = r_carry;
        n_hist    = r_hist;
        n_dval    = r_dval;
        n_char    = r_char;
        n_is_last = r_is_last;
        n_commit  = r_commit;
        n_o_valid = r_o_valid && i_stall;
        n_total   = r_total;
        n_dbz     = r_dbz;
        w_md_ctrl = '0;

        unique case (r_state)
            iaee_pkg::S_IDLE: begin
                if (w_in_accept) begin
                    n_char    = i_char_code;
                    n_is_last = i_is_last;
                    n_commit  = (!w_in_digit && (i_char_code != iaee_pkg::CH_SPACE))
                                || i_is_last;
                    n_dval    = 4'(i_char_code - iaee_pkg::CH_ZERO);
                    n_hist    = '0;
                    n_carry   = '0;
                    n_cnt     = '0;
                    if (w_in_digit) begin
                        n_state = iaee_pkg::S_DIGIT;
                    end else if (n_commit) begin
                        n_state = iaee_pkg::S_COMMIT;
                    end
                end
            end
            iaee_pkg::S_DIGIT: begin
                n_cur   = {w_dig_sum[0], r_cur[VALUE_WIDTH-1:1]};
                n_hist  = {r_hist[1:0], r_cur[0]};
                n_carry = w_dig_sum[2:1];
                n_dval  = {1'b0, r_dval[3:1]};
                if (w_cnt_end) begin
                    n_cnt   = '0;
                    n_state = r_commit ? iaee_pkg::S_COMMIT : iaee_pkg::S_IDLE;
                end else begin
                    n_cnt = r_cnt + CW'(1);
                end
            end
            iaee_pkg::S_COMMIT: begin
                unique case (r_op) inside
                    iaee_pkg::OP_PLUS, iaee_pkg::OP_MINUS: begin
                        n_carry = 2'b10;
                        n_state = iaee_pkg::S_ADD;
                    end
                    iaee_pkg::OP_TIMES: begin
                        w_md_ctrl.start = 1'b1;
                        n_state         = iaee_pkg::S_MULDIV;
                    end
                    iaee_pkg::OP_DIVIDE: begin
                        if (r_cur == '0) begin
                            n_err   = 1'b1;
                            n_last  = '0;
                            n_state = iaee_pkg::S_FINISH;
                        end else begin
                            w_md_ctrl.start  = 1'b1;
                            w_md_ctrl.is_div = 1'b1;
                            n_state          = iaee_pkg::S_MULDIV;
                        end
                    end
                    default: begin
                        // unknown operator: the number is discarded
                        n_state = iaee_pkg::S_FINISH;
                    end
                endcase
            end
            iaee_pkg::S_ADD: begin
                n_sum      = {w_add_bit, r_sum[VALUE_WIDTH-1:1]};
                n_last     = {(r_op == iaee_pkg::OP_MINUS) ? w_neg_bit : r_cur[0],
                              r_last[VALUE_WIDTH-1:1]};
                n_cur      = {1'b0, r_cur[VALUE_WIDTH-1:1]};
                n_carry    = {w_neg_carry, w_add_carry};
                if (w_cnt_end) begin
                    n_cnt   = '0;
                    n_state = iaee_pkg::S_FINISH;
                end else begin
                    n_cnt = r_cnt + CW'(1);
                end
            end
            iaee_pkg::S_MULDIV: begin
                if (w_md_done) begin
                    n_last  = w_md_result;
                    n_state = iaee_pkg::S_FINISH;
                end
            end
            iaee_pkg::S_FINISH: begin
                n_cur   = '0;
                n_op    = iaee_pkg::op_code(r_char);
                n_carry = '0;
                n_state = r_is_last ? iaee_pkg::S_FINAL : iaee_pkg::S_IDLE;
            end
            iaee_pkg::S_FINAL: begin
                n_sum   = {w_add_bit, r_sum[VALUE_WIDTH-1:1]};
                n_last  = {1'b0, r_last[VALUE_WIDTH-1:1]};
                n_carry = {1'b0, w_add_carry};
                if (w_cnt_end) begin
                    n_cnt   = '0;
                    n_state = iaee_pkg::S_EMIT;
                end else begin
                    n_cnt = r_cnt + CW'(1);
                end
            end
            iaee_pkg::S_EMIT: begin
                // wait for the output register to free up
                if (!r_o_valid || !i_stall) begin
                    n_o_valid = 1'b1;
                    n_total   = r_err ? '0 : w_ext;
                    n_dbz     = r_err;
                    n_sum     = '0;
                    n_last    = '0;
                    n_cur     = '0;
                    n_op      = iaee_pkg::OP_PLUS;
                    n_err     = 1'b0;
                    n_state   = iaee_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = iaee_pkg::S_IDLE;
            end
        endcase
    end

    assign o_valid          = r_o_valid;
    assign o_total          = r_total;
    assign o_divide_by_zero = r_dbz;

endmodule

>>> design/iaee_checker.sv
// port-level checks for the infix expression evaluator, bound to the top level
// depends on iaee_pkg and infix_arith_expression_evaluator
module iaee_checker (
    input logic                                    i_clk,
    input logic                                    i_rst_n,
    input logic                                    i_valid,
    input logic                                    o_stall,
    input logic [iaee_pkg::CHAR_WIDTH-1:0]         i_char_code,
    input logic                                    i_is_last,
    input logic                                    o_valid,
    input logic                                    i_stall,
    input logic signed [iaee_pkg::TOTAL_WIDTH-1:0] o_total,
    input logic                                    o_divide_by_zero
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_total) && $stable(o_divide_by_zero))
        else $error("result changed while stalled");

    // divide by zero forces a zero total
    a_dbz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_divide_by_zero |-> o_total == '0)
        else $error("divide by zero with nonzero total");

    // the last item always needs work before a result
    a_last_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && i_is_last |=> o_stall)
        else $error("last item did not start evaluation");

    // a space in the middle of an expression is absorbed at once
    a_space_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && !i_is_last && (i_char_code == iaee_pkg::CH_SPACE)
        |=> !o_stall)
        else $error("space item stalled the input");

    // a new result appears only after the block was busy
    a_rise_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(o_stall))
        else $error("result without evaluation");

endmodule

bind infix_arith_expression_evaluator iaee_checker u_iaee_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_valid         (i_valid),
    .o_stall         (o_stall),
    .i_char_code     (i_char_code),
    .i_is_last       (i_is_last),
    .o_valid         (o_valid),
    .i_stall         (i_stall),
    .o_total         (o_total),
    .o_divide_by_zero(o_divide_by_zero)
);

>>> sim/infix_arith_expression_evaluator_tb.sv
// testbench of the streaming infix expression evaluator: directed and random expressions,
// totals predicted per character and checked in order; depends on iaee_pkg and the top level
module infix_arith_expression_evaluator_tb;
    import iaee_pkg::*;

    localparam int VW              = VALUE_WIDTH_DEF;
    localparam int MAX_ITEM_CYCLES = 3 * VW + 6;
    localparam int TAIL_CYCLES     = 2 * MAX_ITEM_CYCLES;
    localparam int WATCHDOG_LIMIT  = 20 * MAX_ITEM_CYCLES;
    localparam int MAX_WAIT        = 18;
    localparam int MAX_REPORTS     = 10;
    localparam int TARGET_CHARS    = 1000;

    typedef struct {
        logic [CHAR_WIDTH-1:0] code;
        logic                  last;
        bit                    drain;
    } t_char_item;

    typedef struct {
        logic signed [TOTAL_WIDTH-1:0] total;
        logic                          dbz;
    } t_total;

    logic                          i_clk            = 1'b0;
    logic                          i_rst_n          = 1'b0;
    logic                          i_valid          = 1'b0;
    logic                          o_stall;
    logic [CHAR_WIDTH-1:0]         i_char_code      = '0;
    logic                          i_is_last        = 1'b0;
    logic                          o_valid;
    logic                          i_stall          = 1'b0;
    logic signed [TOTAL_WIDTH-1:0] o_total;
    logic                          o_divide_by_zero;

    infix_arith_expression_evaluator u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_char_code      (i_char_code),
        .i_is_last        (i_is_last),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_total          (o_total),
        .o_divide_by_zero (o_divide_by_zero)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // expected evaluator state
    logic [VW-1:0] sum_q;
    logic [VW-1:0] term_q;
    logic [VW-1:0] number_q;
    t_op           op_q;
    logic          div_err_q;

    t_char_item pending_chars[$];
    t_total     expected_totals[$];

    int chars_queued;
    int chars_accepted   = 0;
    int totals_predicted = 0;
    int results_seen     = 0;
    int fail_count       = 0;
    int idle_cycles      = 0;
    int tx_gap           = 0;
    int tx_calm          = 0;
    int rx_gap           = 0;
    int rx_calm          = 0;

    function automatic void clear_expr();
        sum_q     = '0;
        term_q    = '0;
        number_q  = '0;
        op_q      = OP_PLUS;
        div_err_q = 1'b0;
    endfunction

    function automatic t_op op_of_char(input logic [CHAR_WIDTH-1:0] c);
        case (c)
            CH_PLUS:   return OP_PLUS;
            CH_MINUS:  return OP_MINUS;
            CH_TIMES:  return OP_TIMES;
            CH_DIVIDE: return OP_DIVIDE;
            default:   return OP_DROP;
        endcase
    endfunction

    // signed division truncating toward zero, wrapping the most negative value over -1
    function automatic logic [VW-1:0] div_trunc(input logic [VW-1:0] a, input logic [VW-1:0] b);
        logic [VW-1:0] ma;
        logic [VW-1:0] mb;
        logic [VW-1:0] q;
        ma = a[VW-1] ? -a : a;
        mb = b[VW-1] ? -b : b;
        q  = ma / mb;
        return (a[VW-1] ^ b[VW-1]) ? -q : q;
    endfunction

    function automatic void commit_term();
        case (op_q)
            OP_PLUS: begin
                sum_q  = sum_q + term_q;
                term_q = number_q;
            end
            OP_MINUS: begin
                sum_q  = sum_q + term_q;
                term_q = -number_q;
            end
            OP_TIMES: begin
                term_q = term_q * number_q;
            end
            OP_DIVIDE: begin
                if (number_q == '0) begin
                    div_err_q = 1'b1;
                    term_q    = '0;
                end else begin
                    term_q = div_trunc(term_q, number_q);
                end
            end
            default: begin
                // dropped operator discards the number
            end
        endcase
        number_q = '0;
    endfunction

    // advances the expected state by one character; returns 1 when a total is due
    function automatic bit eval_char(input logic [CHAR_WIDTH-1:0] c, input logic last,
                                     output t_total res);
        logic          dig;
        logic [VW-1:0] s;
        dig       = (c >= CH_ZERO) && (c <= CH_NINE);
        res.total = '0;
        res.dbz   = 1'b0;
        if (dig) begin
            number_q = number_q * VW'(10) + VW'(c - CH_ZERO);
        end
        if ((!dig && c != CH_SPACE) || last) begin
            commit_term();
            op_q = op_of_char(c);
        end
        if (!last) begin
            return 1'b0;
        end
        s = sum_q + term_q;
        if (div_err_q) begin
            res.dbz = 1'b1;
        end else begin
            res.total = $signed(s);
        end
        clear_expr();
        return 1'b1;
    endfunction

    // wait before the next item, with occasional stretches of back-to-back items
    function automatic int draw_wait(inout int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 39) == 0) begin
            calm = $urandom_range(20, 80);
            return 0;
        end
        return $urandom_range(0, MAX_WAIT);
    endfunction

    task automatic push_text(input logic [CHAR_WIDTH-1:0] text[$], input bit drain);
        t_char_item item;
        for (int i = 0; i < text.size(); i++) begin
            item.code  = text[i];
            item.last  = (i == text.size() - 1);
            item.drain = drain && (i == 0);
            pending_chars.push_back(item);
        end
    endtask

    task automatic push_expr(input string s, input bit drain);
        logic [CHAR_WIDTH-1:0] text[$];
        for (int i = 0; i < s.len(); i++) begin
            text.push_back(s[i]);
        end
        push_text(text, drain);
    endtask

    task automatic gen_expr(input bit drain);
        logic [CHAR_WIDTH-1:0] text[$];
        int                    kind;
        int                    sel;
        int                    ndig;
        kind = $urandom_range(0, 19);
        if (kind == 0) begin
            repeat ($urandom_range(1, 8)) text.push_back(CHAR_WIDTH'($urandom));
            push_text(text, drain);
        end else if (kind == 1) begin
            // most negative value over minus one
            push_expr("2147483648/4294967295", drain);
        end else begin
            for (int t = 0; t < $urandom_range(1, 6); t++) begin
                if (t > 0) begin
                    if ($urandom_range(0, 3) == 0) text.push_back(CH_SPACE);
                    sel = $urandom_range(0, 15);
                    text.push_back(sel < 4  ? CH_PLUS :
                                   sel < 8  ? CH_MINUS :
                                   sel < 11 ? CH_TIMES :
                                   sel < 15 ? CH_DIVIDE : CHAR_WIDTH'($urandom));
                    if ($urandom_range(0, 3) == 0) text.push_back(CH_SPACE);
                end
                sel  = $urandom_range(0, 15);
                ndig = sel < 10 ? $urandom_range(1, 2) :
                       sel < 14 ? $urandom_range(3, 6) : $urandom_range(9, 12);
                repeat (ndig) text.push_back(CH_ZERO + CHAR_WIDTH'($urandom_range(0, 9)));
            end
            // odd endings: trailing space or stray byte as the last character
            sel = $urandom_range(0, 15);
            if (sel == 0) begin
                text.push_back(CH_SPACE);
            end else if (sel == 1) begin
                text.push_back(CHAR_WIDTH'($urandom));
            end
            push_text(text, drain);
        end
    endtask

    // sender
    always @(posedge i_clk) begin
        t_total     res;
        t_char_item item;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                chars_accepted <= chars_accepted + 1;
                if (eval_char(i_char_code, i_is_last, res)) begin
                    expected_totals.push_back(res);
                    totals_predicted <= totals_predicted + 1;
                end
                tx_gap = draw_wait(tx_calm);
            end
            if (i_valid && o_stall) begin
                // hold the stalled item
            end else if (tx_gap > 0) begin
                tx_gap--;
                i_valid <= 1'b0;
            end else if (pending_chars.size() != 0 &&
                         !(pending_chars[0].drain && expected_totals.size() != 0)) begin
                item = pending_chars.pop_front();
                i_valid     <= 1'b1;
                i_char_code <= item.code;
                i_is_last   <= item.last;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // receiver and checker
    always @(posedge i_clk) begin
        t_total want;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                results_seen <= results_seen + 1;
                if (expected_totals.size() == 0) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS) begin
                        $display("unexpected total %0d dbz %0b", o_total, o_divide_by_zero);
                    end
                end else begin
                    want = expected_totals.pop_front();
                    if (o_total !== want.total || o_divide_by_zero !== want.dbz) begin
                        fail_count++;
                        if (fail_count <= MAX_REPORTS) begin
                            $display("total mismatch: expected %0d dbz %0b, got %0d dbz %0b",
                                     want.total, want.dbz, o_total, o_divide_by_zero);
                        end
                    end
                end
                rx_gap = draw_wait(rx_calm);
            end
            if (rx_gap > 0) begin
                rx_gap--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // watchdog on cycles without any item moving
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("[infix_arith_expression_evaluator] ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int n_expr;
        clear_expr();
        push_expr("3+2*2", 1'b0);
        push_expr("-8/3", 1'b0);
        push_expr("7/0", 1'b0);
        push_expr("5%3", 1'b0);
        push_expr("9/ 2", 1'b0);
        push_expr("4 ", 1'b0);
        push_expr("\377", 1'b0);
        n_expr = 0;
        while (pending_chars.size() < TARGET_CHARS) begin
            // now and then hold off until all totals are back
            gen_expr(n_expr % 40 == 0);
            n_expr++;
        end
        chars_queued = pending_chars.size();

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do begin
            @(posedge i_clk);
        end while (chars_accepted != chars_queued || totals_predicted != results_seen);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && expected_totals.size() == 0) begin
            $display("[infix_arith_expression_evaluator] OK");
        end else begin
            $display("[infix_arith_expression_evaluator] ERROR");
        end
        $finish;
    end

endmodule
